// ===== rtl/wuls_pkg.sv =====
package wuls_pkg;

	// display size used for the visibility flag
	localparam int DISP_WIDTH  = 128;
	localparam int DISP_HEIGHT = 32;

	// coordinate, accumulator and shade widths
	localparam int CW      = 12;
	localparam int ACC_W   = 32;
	localparam int SHADE_W = 4;
	localparam int W_LSB   = ACC_W - SHADE_W;
	localparam logic [SHADE_W-1:0] SHADE_FULL = 4'hF;

	// depth of the command queue between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		KIND_STRAIGHT,
		KIND_YMAJOR,
		KIND_XMAJOR
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAIR,
		ST_DIV
	} bst_t;

	// classified command handed from front to back
	typedef struct packed {
		logic          is_step;
		logic [2:0]    layer;
		logic [CW-1:0] x0;     // top endpoint
		logic [CW-1:0] y0;
		logic [CW-1:0] x1;     // bottom endpoint
		logic [CW-1:0] y1;
		logic [CW-1:0] minor;  // shorter axis length
		logic [CW-1:0] major;  // longer axis length
		kind_t         kind;
		logic          neg;    // x walks toward smaller values
		logic          point;  // both endpoints equal
	} cmd_t;

	// one pixel result
	typedef struct packed {
		logic [2:0]         layer;
		logic [CW-1:0]      x;
		logic [CW-1:0]      y;
		logic [SHADE_W-1:0] shade;
		logic               visible;
		logic               last;
		logic               done;
	} pix_t;

	// pixel lies inside the display
	function automatic logic on_display(input logic [CW-1:0] x, input logic [CW-1:0] y);
		logic xin;
		logic yin;
		xin = !x[CW-1] && ({1'b0, x} < (CW+1)'(DISP_WIDTH));
		yin = !y[CW-1] && ({1'b0, y} < (CW+1)'(DISP_HEIGHT));
		return xin && yin;
	endfunction

	function automatic pix_t make_pix(input logic [2:0] layer, input logic [CW-1:0] x,
			input logic [CW-1:0] y, input logic [SHADE_W-1:0] shade,
			input logic last, input logic done);
		pix_t p;
		p.layer   = layer;
		p.x       = x;
		p.y       = y;
		p.shade   = shade;
		p.visible = on_display(x, y);
		p.last    = last;
		p.done    = done;
		return p;
	endfunction

endpackage

// ===== rtl/wu_antialiased_line_stepper_unit.sv =====
// Channel  Dir  Payload (low bit first)                               Marks
// s_       in   tdata: line_layer 3, start_x 12, start_y 12,          tuser: mode
//               end_x 12, end_y 12, zero fill 5
// m_       out  tdata: out_layer 3, pix_x 12, pix_y 12, shade 4,      tlast: last_of_item
//               visible 1                                             tuser: line_done
//
// A load emits the top endpoint from the back end; a Wu line then occupies the back end
// while the radix-2 divider forms the 32-bit error step, one quotient bit per cycle. A
// straight step emits one pixel, a Wu step two, one at a time through the single output
// register, which holds each pixel while the output is stalled.
// The two-entry command queue accepts items until full, also while the back end is busy
// or the output is stalled. arst_n clears all line state; the block comes up idle.
module wu_antialiased_line_stepper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // line_layer, start_x, start_y, end_x, end_y, zero fill
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_layer, pix_x, pix_y, shade, visible
	output logic        m_tlast,   // last_of_item
	output logic        m_tuser    // line_done
);

	logic           q_valid;
	logic           q_pop;
	wuls_pkg::cmd_t q_cmd;
	wuls_pkg::pix_t pix;

	wuls_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tuser),
		.in_layer (s_tdata[2:0]),
		.in_sx    (s_tdata[14:3]),
		.in_sy    (s_tdata[26:15]),
		.in_ex    (s_tdata[38:27]),
		.in_ey    (s_tdata[50:39]),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd)
	);

	wuls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (pix)
	);

	// pack the result item
	assign m_tdata = {pix.visible, pix.shade, pix.y, pix.x, pix.layer};
	assign m_tlast = pix.last;
	assign m_tuser = pix.done;

endmodule

// ===== rtl/wuls_front.sv =====
module wuls_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_mode,
	input  logic [2:0]              in_layer,
	input  logic [wuls_pkg::CW-1:0] in_sx,
	input  logic [wuls_pkg::CW-1:0] in_sy,
	input  logic [wuls_pkg::CW-1:0] in_ex,
	input  logic [wuls_pkg::CW-1:0] in_ey,
	output logic                    q_valid,
	input  logic                    q_pop,
	output wuls_pkg::cmd_t          q_cmd
);

	localparam int QAW = (wuls_pkg::QDEPTH > 1) ? $clog2(wuls_pkg::QDEPTH) : 1;
	localparam int QCW = $clog2(wuls_pkg::QDEPTH + 1);

	wuls_pkg::cmd_t cmd;
	wuls_pkg::cmd_t fifo_q [wuls_pkg::QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           swap;
	logic [wuls_pkg::CW:0] dx_full;
	logic [wuls_pkg::CW:0] dy_full;
	logic [wuls_pkg::CW-1:0] adx;
	logic [wuls_pkg::CW-1:0] ady;

	// order endpoints top to bottom and classify the line
	always_comb begin
		swap    = $signed(in_sy) > $signed(in_ey);
		cmd.is_step = in_mode;
		cmd.layer   = in_layer;
		cmd.x0      = swap ? in_ex : in_sx;
		cmd.y0      = swap ? in_ey : in_sy;
		cmd.x1      = swap ? in_sx : in_ex;
		cmd.y1      = swap ? in_sy : in_ey;
		dx_full = {cmd.x1[wuls_pkg::CW-1], cmd.x1} - {cmd.x0[wuls_pkg::CW-1], cmd.x0};
		dy_full = {cmd.y1[wuls_pkg::CW-1], cmd.y1} - {cmd.y0[wuls_pkg::CW-1], cmd.y0};
		cmd.neg = dx_full[wuls_pkg::CW];
		adx     = dx_full[wuls_pkg::CW] ? wuls_pkg::CW'(-dx_full) : dx_full[wuls_pkg::CW-1:0];
		ady     = dy_full[wuls_pkg::CW-1:0];
		cmd.point = (adx == '0) && (ady == '0);
		if (adx == '0 || ady == '0 || adx == ady) begin
			cmd.kind  = wuls_pkg::KIND_STRAIGHT;
			cmd.major = (adx > ady) ? adx : ady;
			cmd.minor = (adx > ady) ? ady : adx;
		end else if (ady > adx) begin
			cmd.kind  = wuls_pkg::KIND_YMAJOR;
			cmd.major = ady;
			cmd.minor = adx;
		end else begin
			cmd.kind  = wuls_pkg::KIND_XMAJOR;
			cmd.major = adx;
			cmd.minor = ady;
		end
	end

	assign in_ready = (cnt_q != QCW'(wuls_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(wuls_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(wuls_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/wuls_div.sv =====
module wuls_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wuls_pkg::CW-1:0]    num,
	input  logic [wuls_pkg::CW-1:0]    den,
	output logic                       busy,
	output logic [wuls_pkg::ACC_W-1:0] quot
);

	localparam int NW = $clog2(wuls_pkg::ACC_W);

	logic [wuls_pkg::CW-1:0]    rem_q;
	logic [wuls_pkg::CW-1:0]    den_q;
	logic [wuls_pkg::ACC_W-1:0] quot_q;
	logic [NW-1:0]              cnt_q;
	logic                       busy_q;
	logic [wuls_pkg::CW:0]      rem_sh;
	logic                       ge;
	logic [wuls_pkg::CW:0]      rem_sub;

	// one quotient bit per cycle, restoring; remainder stays below den
	always_comb begin
		rem_sh  = {rem_q, 1'b0};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[wuls_pkg::CW-1:0] : rem_sh[wuls_pkg::CW-1:0];
			quot_q <= {quot_q[wuls_pkg::ACC_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= NW'(wuls_pkg::ACC_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

// ===== rtl/wuls_back.sv =====
module wuls_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  wuls_pkg::cmd_t q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output wuls_pkg::pix_t out_pix
);

	localparam int CW = wuls_pkg::CW;

	wuls_pkg::bst_t  state_q, state_d;
	wuls_pkg::kind_t kind_q, kind_d;
	logic            active_q, active_d;
	logic [CW-1:0]   cur_x_q, cur_x_d;
	logic [CW-1:0]   cur_y_q, cur_y_d;
	logic [CW-1:0]   stop_x_q, stop_x_d;
	logic [CW-1:0]   stop_y_q, stop_y_d;
	logic            neg_q, neg_d;
	logic [CW-1:0]   steps_q, steps_d;
	logic [wuls_pkg::ACC_W-1:0] acc_q, acc_d;
	logic [wuls_pkg::ACC_W-1:0] adj_q, adj_d;
	logic [2:0]      layer_q, layer_d;
	wuls_pkg::pix_t  pend_q, pend_d;
	wuls_pkg::pix_t  opix_q;
	logic            ovalid_q;

	logic            out_free;
	logic            emit;
	wuls_pkg::pix_t  emit_pix;
	logic            div_start;
	logic            div_busy;
	logic [wuls_pkg::ACC_W-1:0] div_quot;

	logic [CW-1:0]   dir;
	logic [wuls_pkg::ACC_W:0] acc_sum;
	logic            wrap;
	logic [wuls_pkg::SHADE_W-1:0] w;
	logic [CW-1:0]   main_x, main_y, nb_x, nb_y;
	logic [CW-1:0]   st_x, st_y;

	wuls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (q_cmd.minor),
		.den    (q_cmd.major),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign out_free = !ovalid_q || out_ready;

	// next pixel positions for straight and Wu steps
	always_comb begin
		dir     = neg_q ? '1 : CW'(1);
		acc_sum = {1'b0, acc_q} + {1'b0, adj_q};
		wrap    = acc_sum[wuls_pkg::ACC_W] || (adj_q == '0);
		w       = acc_sum[wuls_pkg::ACC_W-1:wuls_pkg::W_LSB];
		if (kind_q == wuls_pkg::KIND_YMAJOR) begin
			main_x = wrap ? cur_x_q + dir : cur_x_q;
			main_y = cur_y_q + CW'(1);
			nb_x   = main_x + dir;
			nb_y   = main_y;
		end else begin
			main_x = cur_x_q + dir;
			main_y = wrap ? cur_y_q + CW'(1) : cur_y_q;
			nb_x   = main_x;
			nb_y   = main_y + CW'(1);
		end
		st_x = (cur_x_q != stop_x_q) ? cur_x_q + dir : cur_x_q;
		st_y = (cur_y_q != stop_y_q) ? cur_y_q + CW'(1) : cur_y_q;
	end

	// sequencer: take a command, emit its pixels, run the divider on Wu loads
	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		active_d  = active_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		stop_x_d  = stop_x_q;
		stop_y_d  = stop_y_q;
		neg_d     = neg_q;
		steps_d   = steps_q;
		acc_d     = acc_q;
		adj_d     = adj_q;
		layer_d   = layer_q;
		pend_d    = pend_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_pix  = pend_q;
		div_start = 1'b0;
		case (state_q)
			wuls_pkg::ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (!q_cmd.is_step) begin
						// load a new line, emit its top endpoint
						layer_d  = q_cmd.layer;
						cur_x_d  = q_cmd.x0;
						cur_y_d  = q_cmd.y0;
						stop_x_d = q_cmd.x1;
						stop_y_d = q_cmd.y1;
						neg_d    = q_cmd.neg;
						acc_d    = '0;
						adj_d    = '0;
						kind_d   = q_cmd.kind;
						active_d = !q_cmd.point;
						steps_d  = q_cmd.point ? '0 : q_cmd.major;
						emit     = 1'b1;
						emit_pix = wuls_pkg::make_pix(q_cmd.layer, q_cmd.x0, q_cmd.y0,
							wuls_pkg::SHADE_FULL, 1'b1, q_cmd.point);
						if (!q_cmd.point && q_cmd.kind != wuls_pkg::KIND_STRAIGHT) begin
							div_start = 1'b1;
							state_d   = wuls_pkg::ST_DIV;
						end
					end else if (active_q && steps_q != '0) begin
						if (kind_q == wuls_pkg::KIND_STRAIGHT) begin
							cur_x_d  = st_x;
							cur_y_d  = st_y;
							steps_d  = steps_q - CW'(1);
							active_d = (steps_q != CW'(1));
							emit     = 1'b1;
							emit_pix = wuls_pkg::make_pix(layer_q, st_x, st_y,
								wuls_pkg::SHADE_FULL, 1'b1, steps_q == CW'(1));
						end else if (steps_q == CW'(1)) begin
							// bottom endpoint closes the line
							steps_d  = '0;
							active_d = 1'b0;
							cur_x_d  = stop_x_q;
							cur_y_d  = stop_y_q;
							emit     = 1'b1;
							emit_pix = wuls_pkg::make_pix(layer_q, stop_x_q, stop_y_q,
								wuls_pkg::SHADE_FULL, 1'b1, 1'b1);
						end else begin
							// Wu pair: main pixel now, neighbor from ST_PAIR once the output is free
							acc_d    = acc_sum[wuls_pkg::ACC_W-1:0];
							cur_x_d  = main_x;
							cur_y_d  = main_y;
							steps_d  = steps_q - CW'(1);
							emit     = 1'b1;
							emit_pix = wuls_pkg::make_pix(layer_q, main_x, main_y,
								w ^ wuls_pkg::SHADE_FULL, 1'b0, 1'b0);
							pend_d   = wuls_pkg::make_pix(layer_q, nb_x, nb_y, w, 1'b1, 1'b0);
							state_d  = wuls_pkg::ST_PAIR;
						end
					end
				end
			end
			wuls_pkg::ST_PAIR: begin
				if (out_free) begin
					emit     = 1'b1;
					emit_pix = pend_q;
					state_d  = wuls_pkg::ST_IDLE;
				end
			end
			wuls_pkg::ST_DIV: begin
				if (!div_busy) begin
					adj_d   = div_quot;
					state_d = wuls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wuls_pkg::ST_IDLE;
			end
		endcase
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wuls_pkg::ST_IDLE;
			kind_q   <= wuls_pkg::KIND_STRAIGHT;
			active_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			stop_x_q <= '0;
			stop_y_q <= '0;
			neg_q    <= 1'b0;
			steps_q  <= '0;
			acc_q    <= '0;
			adj_q    <= '0;
			layer_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			active_q <= active_d;
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			stop_x_q <= stop_x_d;
			stop_y_q <= stop_y_d;
			neg_q    <= neg_d;
			steps_q  <= steps_d;
			acc_q    <= acc_d;
			adj_q    <= adj_d;
			layer_q  <= layer_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// pixel payload
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (emit) begin
			opix_q <= emit_pix;
		end
	end

	assign out_valid = ovalid_q;
	assign out_pix   = opix_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int RESET_CYCLES = 11;
	localparam int ITEM_GOAL    = 1200;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RX_PERIOD    = 300;
	localparam bit MODE_LOAD    = 1'b0;
	localparam bit MODE_STEP    = 1'b1;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_COMB,
		RX_SPARSE
	} rx_style_t;

	typedef struct {
		bit        mode;
		bit [2:0]  layer;
		bit [11:0] sx;
		bit [11:0] sy;
		bit [11:0] ex;
		bit [11:0] ey;
	} line_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	wu_antialiased_line_stepper_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	line_cmd_t      line_cmds[$];
	wuls_pkg::pix_t expected_pixels[$];

	int        errors = 0;
	int        cycles = 0;
	int        items_sent = 0;
	int        loads_sent = 0;
	int        pixels_checked = 0;
	int        lines_finished = 0;
	bit        holding = 1'b0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        rx_phase = 0;
	rx_style_t rx_style = RX_OPEN;

	// line state of the predictor, reset values
	logic            ln_active = 1'b0;
	wuls_pkg::kind_t ln_kind = wuls_pkg::KIND_STRAIGHT;
	logic [11:0]     ln_x = '0;
	logic [11:0]     ln_y = '0;
	logic [11:0]     ln_stop_x = '0;
	logic [11:0]     ln_stop_y = '0;
	logic            ln_neg = 1'b0;
	logic [11:0]     ln_steps = '0;
	logic [31:0]     ln_acc = '0;
	logic [31:0]     ln_adj = '0;
	logic [2:0]      ln_layer = '0;

	function automatic void push_pix(input logic [11:0] x, input logic [11:0] y,
			input logic [3:0] shade, input bit last, input bit done);
		wuls_pkg::pix_t p;
		p.layer   = ln_layer;
		p.x       = x;
		p.y       = y;
		p.shade   = shade;
		p.visible = !x[11] && (x < wuls_pkg::DISP_WIDTH) &&
			!y[11] && (y < wuls_pkg::DISP_HEIGHT);
		p.last    = last;
		p.done    = done;
		expected_pixels.push_back(p);
	endfunction

	// expected pixels for one accepted item
	function automatic void trace_line_item(input line_cmd_t c);
		int          x0, y0, x1, y1, t, dx, dy;
		logic [11:0] dir;
		logic [31:0] prev;
		logic [3:0]  w;
		logic [63:0] num;
		if (c.mode == MODE_LOAD) begin
			x0 = int'($signed(c.sx));
			y0 = int'($signed(c.sy));
			x1 = int'($signed(c.ex));
			y1 = int'($signed(c.ey));
			// walk top to bottom
			if (y0 > y1) begin
				t = y0; y0 = y1; y1 = t;
				t = x0; x0 = x1; x1 = t;
			end
			ln_layer  = c.layer;
			ln_x      = 12'(x0);
			ln_y      = 12'(y0);
			ln_stop_x = 12'(x1);
			ln_stop_y = 12'(y1);
			dx        = x1 - x0;
			ln_neg    = dx < 0;
			if (dx < 0)
				dx = -dx;
			dy     = y1 - y0;
			ln_acc = '0;
			ln_adj = '0;
			if (dx == 0 && dy == 0) begin
				ln_active = 1'b0;
				ln_steps  = '0;
				ln_kind   = wuls_pkg::KIND_STRAIGHT;
				push_pix(ln_x, ln_y, wuls_pkg::SHADE_FULL, 1'b1, 1'b1);
				return;
			end
			ln_active = 1'b1;
			if (dy == 0 || dx == 0 || dx == dy) begin
				ln_kind  = wuls_pkg::KIND_STRAIGHT;
				ln_steps = 12'(dx > dy ? dx : dy);
			end else if (dy > dx) begin
				ln_kind  = wuls_pkg::KIND_YMAJOR;
				ln_steps = 12'(dy);
				num      = 64'(dx) << 32;
				ln_adj   = 32'(num / 64'(dy));
			end else begin
				ln_kind  = wuls_pkg::KIND_XMAJOR;
				ln_steps = 12'(dx);
				num      = 64'(dy) << 32;
				ln_adj   = 32'(num / 64'(dx));
			end
			push_pix(ln_x, ln_y, wuls_pkg::SHADE_FULL, 1'b1, 1'b0);
			return;
		end

		// step: nothing happens while idle
		if (!ln_active || ln_steps == 0)
			return;
		dir = ln_neg ? 12'hFFF : 12'h001;
		if (ln_kind == wuls_pkg::KIND_STRAIGHT) begin
			if (ln_x != ln_stop_x)
				ln_x = ln_x + dir;
			if (ln_y != ln_stop_y)
				ln_y = ln_y + 12'd1;
			ln_steps = ln_steps - 12'd1;
			if (ln_steps == 0)
				ln_active = 1'b0;
			push_pix(ln_x, ln_y, wuls_pkg::SHADE_FULL, 1'b1, ln_steps == 0);
			return;
		end
		// Wu line ends on the bottom endpoint at full shade
		if (ln_steps == 12'd1) begin
			ln_steps  = '0;
			ln_active = 1'b0;
			ln_x      = ln_stop_x;
			ln_y      = ln_stop_y;
			push_pix(ln_x, ln_y, wuls_pkg::SHADE_FULL, 1'b1, 1'b1);
			return;
		end
		prev   = ln_acc;
		ln_acc = ln_acc + ln_adj;
		w      = ln_acc[31:28];
		if (ln_kind == wuls_pkg::KIND_YMAJOR) begin
			if (ln_acc <= prev)
				ln_x = ln_x + dir;
			ln_y = ln_y + 12'd1;
			push_pix(ln_x, ln_y, w ^ 4'hF, 1'b0, 1'b0);
			push_pix(ln_x + dir, ln_y, w, 1'b1, 1'b0);
		end else begin
			if (ln_acc <= prev)
				ln_y = ln_y + 12'd1;
			ln_x = ln_x + dir;
			push_pix(ln_x, ln_y, w ^ 4'hF, 1'b0, 1'b0);
			push_pix(ln_x, ln_y + 12'd1, w, 1'b1, 1'b0);
		end
		ln_steps = ln_steps - 12'd1;
	endfunction

	function automatic void add_load(input int layer, input int sx, input int sy,
			input int ex, input int ey);
		line_cmd_t c;
		c.mode  = MODE_LOAD;
		c.layer = 3'(layer);
		c.sx    = 12'(sx);
		c.sy    = 12'(sy);
		c.ex    = 12'(ex);
		c.ey    = 12'(ey);
		line_cmds.push_back(c);
	endfunction

	// step items carry random payload, which the block ignores
	function automatic void add_steps(input int n);
		line_cmd_t c;
		for (int i = 0; i < n; i++) begin
			c.mode  = MODE_STEP;
			c.layer = 3'($urandom);
			c.sx    = 12'($urandom);
			c.sy    = 12'($urandom);
			c.ex    = 12'($urandom);
			c.ey    = 12'($urandom);
			line_cmds.push_back(c);
		end
	endfunction

	function automatic int span(input int sx, input int sy, input int ex, input int ey);
		int ax, ay;
		ax = ex > sx ? ex - sx : sx - ex;
		ay = ey > sy ? ey - sy : sy - ey;
		return ax > ay ? ax : ay;
	endfunction

	function automatic int signed_pick(input int len);
		return $urandom_range(2 * len) - len;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// input side: accept and predict
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			if (line_cmds[0].mode == MODE_LOAD)
				loads_sent++;
			trace_line_item(line_cmds.pop_front());
			holding = 1'b0;
			items_sent++;
		end
	end

	// input side: bursts and gaps
	always @(negedge clk) begin
		if (arst_n && !holding) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (line_cmds.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {5'b0, line_cmds[0].ey, line_cmds[0].ex, line_cmds[0].sy,
					line_cmds[0].sx, line_cmds[0].layer};
				s_tuser  <= line_cmds[0].mode;
				holding = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: stall style is redrawn each time rx_phase reaches a multiple of RX_PERIOD
	always @(negedge clk) begin
		rx_phase++;
		if (rx_phase % RX_PERIOD == 0)
			rx_style = rx_style_t'($urandom_range(3));
		case (rx_style)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(1));
			RX_COMB:   m_tready <= (rx_phase % 5 == 0);
			default:   m_tready <= ($urandom_range(7) == 0);
		endcase
	end

	// output side: compare with oldest expectation
	always @(posedge clk) begin
		wuls_pkg::pix_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel: x %0d, y %0d", $signed(m_tdata[14:3]),
					$signed(m_tdata[26:15]));
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_layer", want.layer, m_tdata[2:0]);
				check_field("pix_x", int'($signed(want.x)), int'($signed(m_tdata[14:3])));
				check_field("pix_y", int'($signed(want.y)), int'($signed(m_tdata[26:15])));
				check_field("shade", want.shade, m_tdata[30:27]);
				check_field("visible", want.visible, m_tdata[31]);
				check_field("last_of_item", want.last, m_tlast);
				check_field("line_done", want.done, m_tuser);
				pixels_checked++;
				if (m_tuser)
					lines_finished++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still expected", cycles,
				expected_pixels.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int planned;
		int sx, sy, ex, ey, len, n, pick;
		line_cmd_t c;

		// directed: idle step, point, straight lines, Wu lines, extremes
		add_steps(1);
		add_load(7, 5, 5, 5, 5);
		add_steps(1);
		add_load(1, 3, 3, 0, 3);
		add_steps(3);
		add_load(2, 2, 2, 2, 0);
		add_steps(2);
		add_load(3, 0, 0, -2, 2);
		add_steps(2);
		add_load(4, 0, 0, 1, 3);
		add_steps(3);
		add_load(5, 3, 1, 0, 2);
		add_steps(3);
		add_load(6, -2048, -2048, 2047, 2047);
		add_steps(2);
		// replaces the diagonal mid-line
		add_load(0, 2047, -2048, -2048, 2046);
		add_steps(2);

		// random: mostly complete short lines around the display
		planned = 0;
		while (planned < ITEM_GOAL) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				sx  = $urandom_range(143) - 8;
				sy  = $urandom_range(47) - 8;
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 150) : $urandom_range(20);
				case ($urandom_range(5))
					0: begin ex = sx + signed_pick(len); ey = sy; end
					1: begin ex = sx; ey = sy + signed_pick(len); end
					2: begin
						ex = sx + (($urandom_range(1) == 1) ? len : -len);
						ey = sy + (($urandom_range(1) == 1) ? len : -len);
					end
					default: begin ex = sx + signed_pick(len); ey = sy + signed_pick(len); end
				endcase
				add_load($urandom_range(7), sx, sy, ex, ey);
				n = span(sx, sy, ex, ey);
				planned += 1 + n;
				case ($urandom_range(9))
					0: add_steps(n > 1 ? $urandom_range(1, n - 1) : n);
					1: add_steps(n + $urandom_range(1, 3));
					default: add_steps(n);
				endcase
			end else if (pick < 85) begin
				// full coordinate range, a few steps
				add_load($urandom_range(7), int'($signed(12'($urandom))),
					int'($signed(12'($urandom))), int'($signed(12'($urandom))),
					int'($signed(12'($urandom))));
				n = $urandom_range(6);
				add_steps(n);
				planned += 1 + n;
			end else begin
				c.mode  = 1'($urandom_range(1));
				c.layer = 3'($urandom);
				c.sx    = 12'($urandom);
				c.sy    = 12'($urandom);
				c.ex    = 12'($urandom);
				c.ey    = 12'($urandom);
				line_cmds.push_back(c);
				if (c.mode == MODE_LOAD)
					planned++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (line_cmds.size() != 0 || holding || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d line loads) over %0d cycles", items_sent, loads_sent,
			cycles);
		$display("Checked %0d pixels, %0d lines walked to their end point", pixels_checked,
			lines_finished);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
